// ===== rtl/lhm_pkg.sv =====
// Shared types and constants for the latency histogram monitor.
package lhm_pkg;

  typedef enum logic [1:0] {
    KIND_RECORD = 2'd0,
    KIND_OPEN   = 2'd1,
    KIND_CLOSE  = 2'd2,
    KIND_QUERY  = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [9:0]  status_code;
    logic [31:0] response_bytes;
    logic [63:0] latency_us;
    logic [16:0] fraction_q16;
  } in_t;

  typedef struct packed {
    logic [19:0] percentile_bound_us;
    logic [47:0] request_count;
    logic [63:0] bytes_sent;
    logic [31:0] open_connections;
    logic [47:0] connection_count;
    logic [47:0] ok_responses;
    logic [47:0] client_error_responses;
    logic [47:0] server_error_responses;
  } out_t;

  localparam int unsigned FRAC_W     = 17;
  localparam int unsigned TOTAL_W    = 64;
  localparam int unsigned BOUND_W    = 20;
  localparam int unsigned NUM_BOUNDS = 14;

  localparam logic [9:0] STATUS_CLIENT_MIN = 10'd400;
  localparam logic [9:0] STATUS_SERVER_MIN = 10'd500;

  // Inclusive upper bounds of the latency bins in microseconds.
  localparam logic [BOUND_W-1:0] BIN_BOUND [NUM_BOUNDS] = '{
    20'd50, 20'd100, 20'd250, 20'd500, 20'd1000, 20'd2500, 20'd5000,
    20'd10000, 20'd25000, 20'd50000, 20'd100000, 20'd250000, 20'd500000,
    20'd1000000
  };

endpackage

// ===== rtl/latency_histogram_monitor.sv =====
// Top level of the latency histogram monitor.
//
// One input channel (in_valid_i / in_stall_o / in_data_i) carries events:
// record a request, open or close a connection, or a percentile query. Each
// accepted transaction produces exactly one result transaction on the output
// channel (out_valid_o / out_stall_i / out_data_o) holding a snapshot of all
// counters, plus the percentile bound for a query.
// One item is in work at a time. A record, open or close is accepted (a record
// also reads its latency bin then) and moves to the finishing state, which writes
// a record's bin back and loads the result register once that register is free.
// A query passes the accepting cycle, the low, high and sum phases of the target
// multiplier, a read of the first bin, a walk over 1 to BUCKETS - 1 bins and the
// result load. A query with no recorded requests skips the multiplier and walk.
// The result register decouples the sides: a stalled result is held while the
// next item is already taken in; the item finishes only once the register frees.
// Reset clears all counters, the bin valid flags (bins read as zero until
// first written) and both handshakes; items are accepted once reset is released.
module latency_histogram_monitor #(
  parameter int unsigned BUCKETS     = 15,
  parameter int unsigned COUNT_WIDTH = 48
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  lhm_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output lhm_pkg::out_t  out_data_o
);

  localparam int unsigned IDX_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam logic [IDX_W-1:0] LAST_WALK = IDX_W'(BUCKETS - 2);

  typedef enum logic [2:0] {
    S_IDLE,
    S_TGT,
    S_WALK,
    S_FIN
  } state_e;

  state_e                   state_q;
  logic                     out_valid_q;
  lhm_pkg::out_t            out_q;
  logic [BUCKETS-1:0]       bin_valid_q;

  logic [COUNT_WIDTH-1:0]   req_q, req_d;
  logic [63:0]              bytes_q, bytes_d;
  logic [31:0]              active_q, active_d;
  logic [COUNT_WIDTH-1:0]   conns_q, conns_d;
  logic [COUNT_WIDTH-1:0]   ok_q, ok_d;
  logic [COUNT_WIDTH-1:0]   client_q, client_d;
  logic [COUNT_WIDTH-1:0]   server_q, server_d;

  lhm_pkg::in_t             item_q;
  logic [IDX_W-1:0]         bin_q;
  logic [IDX_W-1:0]         walk_q;
  logic [63:0]              seen_q;
  logic [lhm_pkg::BOUND_W-1:0] bound_q;

  logic                     accept;
  logic                     out_free;
  logic                     commit;
  logic [IDX_W-1:0]         bin_idx;

  logic                     ram_we;
  logic [COUNT_WIDTH-1:0]   ram_wdata;
  logic                     ram_re;
  logic [IDX_W-1:0]         ram_raddr;
  logic [COUNT_WIDTH-1:0]   ram_rdata;
  logic [COUNT_WIDTH-1:0]   rec_cnt;

  logic                     tgt_start;
  logic                     tgt_done;
  logic [63:0]              target;

  logic [COUNT_WIDTH-1:0]   walk_cnt;
  logic [64:0]              walk_sum;
  logic [63:0]              seen_sat;
  logic                     walk_stop;

  lhm_pkg::out_t            out_d;

  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o = (state_q != S_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign commit     = (state_q == S_FIN) && out_free;

  // First bin whose bound holds the latency; the last bin catches the rest.
  always_comb begin
    bin_idx = IDX_W'(BUCKETS - 1);
    for (int i = BUCKETS - 2; i >= 0; i--) begin
      if (in_data_i.latency_us <= 64'(lhm_pkg::BIN_BOUND[i])) begin
        bin_idx = IDX_W'(i);
      end
    end
  end

  assign tgt_start = accept && (in_data_i.kind == lhm_pkg::KIND_QUERY) && (req_q != '0);

  lhm_target u_target (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (tgt_start),
    .fraction_i (in_data_i.fraction_q16),
    .total_i    (64'(req_q)),
    .done_o     (tgt_done),
    .target_o   (target)
  );

  // Cumulative walk over the bins with a saturating 64-bit sum.
  always_comb begin
    walk_cnt  = bin_valid_q[walk_q] ? ram_rdata : '0;
    walk_sum  = {1'b0, seen_q} + {1'b0, 64'(walk_cnt)};
    seen_sat  = walk_sum[64] ? '1 : walk_sum[63:0];
    walk_stop = (seen_sat >= target) || (walk_q == LAST_WALK);
  end

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = bin_idx;
    if (accept && (in_data_i.kind == lhm_pkg::KIND_RECORD)) begin
      ram_re = 1'b1;
    end else if ((state_q == S_TGT) && tgt_done) begin
      ram_re    = 1'b1;
      ram_raddr = '0;
    end else if ((state_q == S_WALK) && !walk_stop) begin
      ram_re    = 1'b1;
      ram_raddr = walk_q + IDX_W'(1);
    end
  end

  // The bin read at acceptance is still on the read port here: no other read
  // is issued until the item finishes, so the write-back sees current data.
  assign rec_cnt   = bin_valid_q[bin_q] ? ram_rdata : '0;
  assign ram_wdata = rec_cnt + COUNT_WIDTH'(1);
  assign ram_we    = commit && (item_q.kind == lhm_pkg::KIND_RECORD);

  lhm_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (BUCKETS)
  ) u_bins (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (bin_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    req_d    = req_q;
    bytes_d  = bytes_q;
    active_d = active_q;
    conns_d  = conns_q;
    ok_d     = ok_q;
    client_d = client_q;
    server_d = server_q;
    if (commit) begin
      case (item_q.kind)
        lhm_pkg::KIND_RECORD: begin
          req_d   = req_q + COUNT_WIDTH'(1);
          bytes_d = bytes_q + 64'(item_q.response_bytes);
          if (item_q.status_code < lhm_pkg::STATUS_CLIENT_MIN) begin
            ok_d = ok_q + COUNT_WIDTH'(1);
          end else if (item_q.status_code < lhm_pkg::STATUS_SERVER_MIN) begin
            client_d = client_q + COUNT_WIDTH'(1);
          end else begin
            server_d = server_q + COUNT_WIDTH'(1);
          end
        end
        lhm_pkg::KIND_OPEN: begin
          active_d = active_q + 32'd1;
          conns_d  = conns_q + COUNT_WIDTH'(1);
        end
        lhm_pkg::KIND_CLOSE: begin
          if (active_q != '0) begin
            active_d = active_q - 32'd1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    out_d.percentile_bound_us    = bound_q;
    out_d.request_count          = 48'(req_d);
    out_d.bytes_sent             = bytes_d;
    out_d.open_connections       = active_d;
    out_d.connection_count       = 48'(conns_d);
    out_d.ok_responses           = 48'(ok_d);
    out_d.client_error_responses = 48'(client_d);
    out_d.server_error_responses = 48'(server_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      bin_valid_q <= '0;
      req_q       <= '0;
      bytes_q     <= '0;
      active_q    <= '0;
      conns_q     <= '0;
      ok_q        <= '0;
      client_q    <= '0;
      server_q    <= '0;
    end else begin
      req_q    <= req_d;
      bytes_q  <= bytes_d;
      active_q <= active_d;
      conns_q  <= conns_d;
      ok_q     <= ok_d;
      client_q <= client_d;
      server_q <= server_d;
      if (ram_we) begin
        bin_valid_q[bin_q] <= 1'b1;
      end
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            state_q <= tgt_start ? S_TGT : S_FIN;
          end
        end
        S_TGT: begin
          if (tgt_done) begin
            state_q <= S_WALK;
          end
        end
        S_WALK: begin
          if (walk_stop) begin
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q  <= in_data_i;
      bin_q   <= bin_idx;
      bound_q <= '0;
    end
    if ((state_q == S_TGT) && tgt_done) begin
      walk_q <= '0;
      seen_q <= '0;
    end
    if (state_q == S_WALK) begin
      if (walk_stop) begin
        bound_q <= lhm_pkg::BIN_BOUND[walk_q];
      end else begin
        walk_q <= walk_q + IDX_W'(1);
        seen_q <= seen_sat;
      end
    end
    if (commit) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_fin_loads_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> out_valid_q)
    else $error("finished item did not reach the result register");

  a_walk_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK) |-> (walk_q <= LAST_WALK))
    else $error("histogram walk ran past the last bounded bin");

  a_target_in_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tgt_done |-> ((state_q == S_TGT) && (item_q.kind == lhm_pkg::KIND_QUERY)))
    else $error("target unit finished outside a query");

  a_bin_marked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |=> bin_valid_q[$past(bin_q)])
    else $error("written bin not marked valid");

endmodule

// ===== rtl/lhm_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module lhm_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 15
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/lhm_target.sv =====
// Multi-cycle unit that forms the query target (fraction * total) >> 16, saturated.
module lhm_target (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [lhm_pkg::FRAC_W-1:0]   fraction_i,
  input  logic [lhm_pkg::TOTAL_W-1:0]  total_i,
  output logic                         done_o,
  output logic [lhm_pkg::TOTAL_W-1:0]  target_o
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_LO,
    PH_HI,
    PH_SUM
  } phase_e;

  localparam int unsigned PROD_W = lhm_pkg::FRAC_W + 32;
  localparam int unsigned FULL_W = PROD_W + 32;

  phase_e                        phase_q;
  logic                          done_q;
  logic [lhm_pkg::TOTAL_W-1:0]   target_q;
  logic [lhm_pkg::FRAC_W-1:0]    frac_q;
  logic [lhm_pkg::TOTAL_W-1:0]   total_q;
  logic [PROD_W-1:0]             prod_lo_q;
  logic [PROD_W-1:0]             prod_hi_q;
  logic [FULL_W-1:0]             full_prod;
  logic [lhm_pkg::TOTAL_W-1:0]   target_d;

  // The upper partial product carries weight 2^32; dropping 16 bits gives the target.
  always_comb begin
    full_prod = {prod_hi_q, 32'd0} + {32'd0, prod_lo_q};
    target_d  = full_prod[FULL_W-1] ? '1 : full_prod[FULL_W-2:16];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      done_q   <= 1'b0;
      target_q <= '0;
    end else begin
      done_q <= (phase_q == PH_SUM);
      case (phase_q)
        PH_IDLE: begin
          if (start_i) begin
            phase_q <= PH_LO;
          end
        end
        PH_LO: begin
          phase_q <= PH_HI;
        end
        PH_HI: begin
          phase_q <= PH_SUM;
        end
        PH_SUM: begin
          target_q <= target_d;
          phase_q  <= PH_IDLE;
        end
        default: begin
          phase_q <= PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && (phase_q == PH_IDLE)) begin
      frac_q  <= fraction_i;
      total_q <= total_i;
    end
    if (phase_q == PH_LO) begin
      prod_lo_q <= PROD_W'(frac_q) * PROD_W'(total_q[31:0]);
    end
    if (phase_q == PH_HI) begin
      prod_hi_q <= PROD_W'(frac_q) * PROD_W'(total_q[63:32]);
    end
  end

  assign done_o   = done_q;
  assign target_o = target_q;

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the latency histogram monitor.
module testbench;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned RANDOM_ITEMS = 130;
  localparam int unsigned PLAN_ROWS    = 22;

  typedef struct {
    lhm_pkg::in_t                 item;
    logic                         typed;
    logic [lhm_pkg::BOUND_W-1:0]  bound;
  } plan_row_t;

  logic           clk_i = 1'b0;
  logic           rst_ni = 1'b0;
  logic           in_valid_i = 1'b0;
  logic           in_stall_o;
  lhm_pkg::in_t   in_data_i = '0;
  logic           out_valid_o;
  logic           out_stall_i = 1'b0;
  lhm_pkg::out_t  out_data_o;

  int unsigned src_idle_pct = 0;
  int unsigned sink_idle_pct = 0;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;

  // Mirror of the monitor's counters.
  logic [47:0] n_requests;
  logic [63:0] n_bytes;
  logic [31:0] n_active;
  logic [47:0] n_opened;
  logic [47:0] n_ok;
  logic [47:0] n_client_err;
  logic [47:0] n_server_err;
  logic [47:0] bin_count [lhm_pkg::NUM_BOUNDS + 1];

  lhm_pkg::out_t snapshot_q [$];
  plan_row_t plan [PLAN_ROWS];

  latency_histogram_monitor DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  always @(negedge clk_i) out_stall_i <= ($urandom_range(99) < sink_idle_pct);

  // Applies one event to the counter mirror and returns the snapshot it yields.
  function automatic lhm_pkg::out_t monitor_step(input lhm_pkg::in_t it);
    lhm_pkg::out_t snap;
    int unsigned   idx;
    logic [95:0]   prod;
    logic [63:0]   target;
    logic [63:0]   seen;
    logic          found;
    snap = '0;
    case (it.kind)
      lhm_pkg::KIND_RECORD: begin
        n_requests = n_requests + 48'd1;
        n_bytes    = n_bytes + 64'(it.response_bytes);
        if (it.status_code < lhm_pkg::STATUS_CLIENT_MIN) begin
          n_ok = n_ok + 48'd1;
        end else if (it.status_code < lhm_pkg::STATUS_SERVER_MIN) begin
          n_client_err = n_client_err + 48'd1;
        end else begin
          n_server_err = n_server_err + 48'd1;
        end
        idx = lhm_pkg::NUM_BOUNDS;
        for (int i = lhm_pkg::NUM_BOUNDS - 1; i >= 0; i--)
          if (it.latency_us <= 64'(lhm_pkg::BIN_BOUND[i])) idx = i;
        bin_count[idx] = bin_count[idx] + 48'd1;
      end
      lhm_pkg::KIND_OPEN: begin
        n_active = n_active + 32'd1;
        n_opened = n_opened + 48'd1;
      end
      lhm_pkg::KIND_CLOSE: begin
        if (n_active != 0) n_active = n_active - 32'd1;
      end
      default: begin
        if (n_requests != 0) begin
          prod   = 96'(it.fraction_q16) * 96'(n_requests);
          target = prod[79:16];
          seen   = '0;
          found  = 1'b0;
          snap.percentile_bound_us = lhm_pkg::BIN_BOUND[lhm_pkg::NUM_BOUNDS - 1];
          // The catch-all bin never answers; it falls back to the last bound.
          for (int i = 0; i < lhm_pkg::NUM_BOUNDS; i++) begin
            if (!found) begin
              seen = seen + 64'(bin_count[i]);
              if (seen >= target) begin
                snap.percentile_bound_us = lhm_pkg::BIN_BOUND[i];
                found = 1'b1;
              end
            end
          end
        end
      end
    endcase
    snap.request_count          = n_requests;
    snap.bytes_sent             = n_bytes;
    snap.open_connections       = n_active;
    snap.connection_count       = n_opened;
    snap.ok_responses           = n_ok;
    snap.client_error_responses = n_client_err;
    snap.server_error_responses = n_server_err;
    return snap;
  endfunction

  function automatic lhm_pkg::in_t mk(input lhm_pkg::kind_e k, input logic [9:0] st,
                                      input logic [31:0] nb, input logic [63:0] lat,
                                      input logic [16:0] fr);
    lhm_pkg::in_t it;
    it.kind           = k;
    it.status_code    = st;
    it.response_bytes = nb;
    it.latency_us     = lat;
    it.fraction_q16   = fr;
    return it;
  endfunction

  function automatic lhm_pkg::in_t rand_item();
    lhm_pkg::in_t it;
    int unsigned  pick;
    int unsigned  b;
    pick = $urandom_range(99);
    b    = $urandom_range(lhm_pkg::NUM_BOUNDS - 1);
    if (pick < 50) begin
      it.kind = lhm_pkg::KIND_RECORD;
    end else if (pick < 70) begin
      it.kind = lhm_pkg::KIND_OPEN;
    end else if (pick < 85) begin
      it.kind = lhm_pkg::KIND_CLOSE;
    end else begin
      it.kind = lhm_pkg::KIND_QUERY;
    end
    case ($urandom_range(3))
      0: it.status_code = 10'($urandom_range(1023));
      1: it.status_code = 10'($urandom_range(401, 398));
      2: it.status_code = 10'($urandom_range(501, 498));
      default: it.status_code = 10'($urandom_range(599, 100));
    endcase
    it.response_bytes = $urandom;
    // One latency pick in four clusters around a bin edge so that every boundary is hit.
    case ($urandom_range(3))
      0: it.latency_us = {$urandom, $urandom};
      1: it.latency_us = 64'(lhm_pkg::BIN_BOUND[b]) + 64'($urandom_range(2)) - 64'd1;
      2: it.latency_us = 64'($urandom_range(1000000));
      default: it.latency_us = 64'($urandom_range(3000));
    endcase
    if ($urandom_range(9) == 0) begin
      it.fraction_q16 = 17'($urandom_range(131071));
    end else begin
      it.fraction_q16 = 17'($urandom_range(65536));
    end
    return it;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_item(input lhm_pkg::in_t it, input logic typed,
                           input logic [lhm_pkg::BOUND_W-1:0] bound);
    lhm_pkg::out_t snap;
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    snap = monitor_step(it);
    if (typed) snap.percentile_bound_us = bound;
    snapshot_q.push_back(snap);
    @(negedge clk_i);
  endtask

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin
    lhm_pkg::out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (snapshot_q.size() == 0) begin
        $error("result transaction with no expectation pending");
        mismatches++;
      end else begin
        want = snapshot_q.pop_front();
        check_field("percentile_bound_us", 64'(want.percentile_bound_us),
                    64'(out_data_o.percentile_bound_us));
        check_field("request_count", 64'(want.request_count), 64'(out_data_o.request_count));
        check_field("bytes_sent", want.bytes_sent, out_data_o.bytes_sent);
        check_field("open_connections", 64'(want.open_connections),
                    64'(out_data_o.open_connections));
        check_field("connection_count", 64'(want.connection_count),
                    64'(out_data_o.connection_count));
        check_field("ok_responses", 64'(want.ok_responses), 64'(out_data_o.ok_responses));
        check_field("client_error_responses", 64'(want.client_error_responses),
                    64'(out_data_o.client_error_responses));
        check_field("server_error_responses", 64'(want.server_error_responses),
                    64'(out_data_o.server_error_responses));
      end
    end
  end

  initial begin
    n_requests   = '0;
    n_bytes      = '0;
    n_active     = '0;
    n_opened     = '0;
    n_ok         = '0;
    n_client_err = '0;
    n_server_err = '0;
    foreach (bin_count[i]) bin_count[i] = '0;

    // Bounds are typed in only where the answer is plain from the bin contents.
    plan = '{
      '{mk(lhm_pkg::KIND_QUERY,  10'd0,    32'd0,         64'd0,       17'd65536), 1'b1, 20'd0},
      '{mk(lhm_pkg::KIND_CLOSE,  10'd0,    32'd0,         64'd0,       17'd0), 1'b1, 20'd0},
      '{mk(lhm_pkg::KIND_RECORD, 10'd0,    32'd0,         64'd0,       17'd0), 1'b0, 20'd0},
      '{mk(lhm_pkg::KIND_RECORD, 10'd399,  32'hFFFF_FFFF, 64'd50,      17'd0), 1'b0, 20'd0},
      '{mk(lhm_pkg::KIND_RECORD, 10'd400,  32'd1,         64'd51,      17'd0), 1'b0, 20'd0},
      '{mk(lhm_pkg::KIND_RECORD, 10'd499,  32'd2,         64'd1000000, 17'd0), 1'b0, 20'd0},
      '{mk(lhm_pkg::KIND_RECORD, 10'd500,  32'd3,         64'd1000001, 17'd0), 1'b0, 20'd0},
      '{mk(lhm_pkg::KIND_RECORD, 10'd1023, 32'h8000_0000, '1,          17'd0), 1'b0, 20'd0},
      '{mk(lhm_pkg::KIND_QUERY,  10'd0,    32'd0,         64'd0,       17'd0), 1'b1, 20'd50},
      '{mk(lhm_pkg::KIND_QUERY,  10'd0,    32'd0,         64'd0,       17'd65536), 1'b1,
        20'd1000000},
      '{mk(lhm_pkg::KIND_QUERY,  10'd0,    32'd0,         64'd0,       17'h1FFFF), 1'b1,
        20'd1000000},
      '{mk(lhm_pkg::KIND_QUERY,  10'd0,    32'd0,         64'd0,       17'd32768), 1'b1, 20'd100},
      '{mk(lhm_pkg::KIND_OPEN,   10'd0,    32'd0,         64'd0,       17'd0), 1'b0, 20'd0},
      '{mk(lhm_pkg::KIND_OPEN,   10'd0,    32'd0,         64'd0,       17'd0), 1'b0, 20'd0},
      '{mk(lhm_pkg::KIND_CLOSE,  10'd0,    32'd0,         64'd0,       17'd0), 1'b0, 20'd0},
      '{mk(lhm_pkg::KIND_CLOSE,  10'd0,    32'd0,         64'd0,       17'd0), 1'b0, 20'd0},
      '{mk(lhm_pkg::KIND_CLOSE,  10'd0,    32'd0,         64'd0,       17'd0), 1'b0, 20'd0},
      '{mk(lhm_pkg::KIND_RECORD, 10'd200,  32'd100,       64'd250,     17'd0), 1'b0, 20'd0},
      '{mk(lhm_pkg::KIND_RECORD, 10'd302,  32'd0,         64'd251,     17'd0), 1'b0, 20'd0},
      '{mk(lhm_pkg::KIND_RECORD, 10'd404,  32'd0,         64'd2500,    17'd0), 1'b0, 20'd0},
      '{mk(lhm_pkg::KIND_QUERY,  10'd0,    32'd0,         64'd0,       17'd1), 1'b1, 20'd50},
      '{mk(lhm_pkg::KIND_QUERY,  10'd0,    32'd0,         64'd0,       17'd65535), 1'b0, 20'd0}
    };

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          src_idle_pct  = 11;
          sink_idle_pct = 56;
        end
        1: begin
          src_idle_pct  = 56;
          sink_idle_pct = 11;
        end
        default: begin
          src_idle_pct  = 0;
          sink_idle_pct = 0;
        end
      endcase
      if (ph == 0) begin
        foreach (plan[i]) send_item(plan[i].item, plan[i].typed, plan[i].bound);
      end
      repeat (RANDOM_ITEMS) send_item(rand_item(), 1'b0, '0);
      // Hold the input off until every snapshot of this phase has come back.
      in_valid_i <= 1'b0;
      while (snapshot_q.size() != 0) @(negedge clk_i);
    end

    // Leave room for any unexpected result transaction to show up before the verdict.
    repeat (5) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/lhm_pkg.sv
rtl/lhm_ram.sv
rtl/lhm_target.sv
rtl/latency_histogram_monitor.sv
tb/sv/testbench.sv
